/* sv/mwsp_pkg.sv */
// Package for the mecanum wheel speed to PWM block.
// Holds widths, pipeline stage indexes, register indexes and shared types.
// No dependencies.
package mwsp_pkg;

    localparam int VEL_W      = 16;
    localparam int RADIUS_W   = 10;
    localparam int HALF_W     = 10;
    localparam int ARM_W      = HALF_W + 1;
    localparam int GEAR_W     = 8;
    localparam int RPM_W      = 16;
    localparam int PWM_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int VX_W  = 26;
    localparam int ROT_W = 27;
    localparam int N_W   = 28;
    localparam int MAG_W = N_W - 1;

    localparam int PROD_W  = MAG_W + GEAR_W;
    localparam int NUM60_W = PROD_W + 6;
    localparam int FRAC_W  = 12;
    localparam int NUM_W   = NUM60_W + FRAC_W;
    localparam int DN_W    = NUM_W + PWM_W;
    localparam int REM_W   = DN_W + 1;

    localparam int TWO_PI_W = 25;
    localparam int RM_W     = RADIUS_W + RPM_W;
    localparam int DEN_W    = RM_W + TWO_PI_W;

    localparam logic [TWO_PI_W-1:0] TWO_PI_K = TWO_PI_W'(25735927);
    localparam logic signed [VX_W-1:0] MM_PER_M = VX_W'(1000);

    localparam int NUM_WHEELS = 4;
    localparam int DIV_BITS   = PWM_W;

    localparam int ST_IN       = 1;
    localparam int ST_SUM      = 2;
    localparam int ST_MAG      = 3;
    localparam int ST_PROD     = 4;
    localparam int ST_NUM      = 5;
    localparam int ST_MUL      = 6;
    localparam int ST_DIVIN    = 7;
    localparam int ST_DIV0     = 8;
    localparam int ST_DIV_LAST = ST_DIV0 + DIV_BITS - 1;
    localparam int ST_OUT      = ST_DIV_LAST + 1;
    localparam int NUM_STAGES  = ST_OUT;

    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GEAR_RATIO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RPM      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PWM      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PWM      = 3'd6;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(40);
    localparam logic [HALF_W-1:0]   HALF_RST   = HALF_W'(100);
    localparam logic [GEAR_W-1:0]   GEAR_RST   = GEAR_W'(48);
    localparam logic [RPM_W-1:0]    RPM_RST    = RPM_W'(200);
    localparam logic [PWM_W-1:0]    MIN_PWM_RST = PWM_W'(0);
    localparam logic [PWM_W-1:0]    MAX_PWM_RST = PWM_W'(255);

    typedef logic [NUM_STAGES:1] stage_vec_t;
    typedef logic signed [N_W-1:0] wheel_rate_t;

    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic [ARM_W-1:0]    arm;
        logic [GEAR_W-1:0]   gear;
        logic [DEN_W-1:0]    den;
        logic [PWM_W-1:0]    lo;
        logic [PWM_W-1:0]    hi;
        logic [PWM_W-1:0]    span;
        logic                down;
    } cfg_t;

    typedef struct packed {
        logic dir;
        logic dead;
        logic cap;
    } wheel_flags_t;

endpackage

/* sv/mwsp_cmd_if.sv */
// Command channel: valid/ready handshake carrying one body velocity command.
// Depends on mwsp_pkg for field widths.
interface mwsp_cmd_if;
    logic                               valid;
    logic                               ready;
    logic signed [mwsp_pkg::VEL_W-1:0]  vel_x;
    logic signed [mwsp_pkg::VEL_W-1:0]  vel_y;
    logic signed [mwsp_pkg::VEL_W-1:0]  yaw_rate;

    modport source (output valid, output vel_x, output vel_y, output yaw_rate, input ready);
    modport sink   (input valid, input vel_x, input vel_y, input yaw_rate, output ready);
endinterface

/* sv/mwsp_pwm_if.sv */
// Result channel: valid/ready handshake carrying duty and direction per wheel.
// Depends on mwsp_pkg for field widths.
interface mwsp_pwm_if;
    logic                         valid;
    logic                         ready;
    logic [mwsp_pkg::PWM_W-1:0]   pwm_left_front;
    logic                         dir_left_front;
    logic [mwsp_pkg::PWM_W-1:0]   pwm_right_front;
    logic                         dir_right_front;
    logic [mwsp_pkg::PWM_W-1:0]   pwm_left_back;
    logic                         dir_left_back;
    logic [mwsp_pkg::PWM_W-1:0]   pwm_right_back;
    logic                         dir_right_back;

    modport source (
        output valid, input ready,
        output pwm_left_front, output dir_left_front,
        output pwm_right_front, output dir_right_front,
        output pwm_left_back, output dir_left_back,
        output pwm_right_back, output dir_right_back
    );
    modport sink (
        input valid, output ready,
        input pwm_left_front, input dir_left_front,
        input pwm_right_front, input dir_right_front,
        input pwm_left_back, input dir_left_back,
        input pwm_right_back, input dir_right_back
    );
endinterface

/* sv/mwsp_kin.sv */
// Inverse kinematics stages: scales the body command and forms the four
// signed wheel rate numerators. Depends on mwsp_pkg.
module mwsp_kin (
    input  logic                                 clk,
    input  mwsp_pkg::stage_vec_t                 en,
    input  mwsp_pkg::cfg_t                       cfg,
    input  logic signed [mwsp_pkg::VEL_W-1:0]    vel_x,
    input  logic signed [mwsp_pkg::VEL_W-1:0]    vel_y,
    input  logic signed [mwsp_pkg::VEL_W-1:0]    yaw_rate,
    output mwsp_pkg::wheel_rate_t                rate [mwsp_pkg::NUM_WHEELS]
);
    import mwsp_pkg::*;

    logic signed [VX_W-1:0]  vx_next;
    logic signed [VX_W-1:0]  vy_next;
    logic signed [ROT_W-1:0] rot_next;
    logic signed [VX_W-1:0]  vx_reg;
    logic signed [VX_W-1:0]  vy_reg;
    logic signed [ROT_W-1:0] rot_reg;
    logic signed [N_W-1:0]   vx_ext;
    logic signed [N_W-1:0]   vy_ext;
    logic signed [N_W-1:0]   rot_ext;
    wheel_rate_t             rate_reg [NUM_WHEELS];

    assign vx_next  = VX_W'(vel_x) * MM_PER_M;
    assign vy_next  = VX_W'(vel_y) * MM_PER_M;
    assign rot_next = ROT_W'(yaw_rate) * ROT_W'(signed'({1'b0, cfg.arm}));

    always_ff @(posedge clk)
    begin
        if (en[ST_IN])
        begin
            vx_reg  <= vx_next;
            vy_reg  <= vy_next;
            rot_reg <= rot_next;
        end
    end

    assign vx_ext  = N_W'(vx_reg);
    assign vy_ext  = N_W'(vy_reg);
    assign rot_ext = N_W'(rot_reg);

    // left front, right front, left back, right back
    always_ff @(posedge clk)
    begin
        if (en[ST_SUM])
        begin
            rate_reg[0] <= vx_ext - vy_ext - rot_ext;
            rate_reg[1] <= vx_ext + vy_ext + rot_ext;
            rate_reg[2] <= vx_ext + vy_ext - rot_ext;
            rate_reg[3] <= vx_ext - vy_ext + rot_ext;
        end
    end

    assign rate = rate_reg;

endmodule

/* sv/mwsp_wheel.sv */
// Per-wheel scaling pipeline: magnitude, dead zone, rpm ratio, cap and an
// eight-stage restoring divider for the rounded duty. Depends on mwsp_pkg.
module mwsp_wheel (
    input  logic                          clk,
    input  mwsp_pkg::stage_vec_t          en,
    input  mwsp_pkg::cfg_t                cfg,
    input  mwsp_pkg::wheel_rate_t         rate,
    output logic [mwsp_pkg::PWM_W-1:0]    duty,
    output logic                          dir
);
    import mwsp_pkg::*;

    logic [MAG_W-1:0]   mag_next;
    logic               dead_next;
    logic [MAG_W-1:0]   mag_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [NUM60_W-1:0] num60_reg;
    logic [NUM_W-1:0]   num_full;
    logic               cap_next;
    logic [DN_W-1:0]    dn_reg;
    logic [REM_W-1:0]   rem_reg [ST_DIVIN:ST_DIV_LAST-1];
    logic [PWM_W-1:0]   q_reg   [ST_DIVIN:ST_DIV_LAST];
    wheel_flags_t       flag_reg [ST_MAG:ST_DIV_LAST];
    logic [PWM_W-1:0]   duty_next;
    logic [PWM_W-1:0]   duty_reg;
    logic               dir_reg;

    assign mag_next  = rate[N_W-1] ? MAG_W'(-rate) : MAG_W'(rate);
    assign dead_next = (cfg.radius == '0) || (mag_next < MAG_W'(cfg.radius));
    assign num_full  = {num60_reg, {FRAC_W{1'b0}}};
    assign cap_next  = num_full >= NUM_W'(cfg.den);

    always_ff @(posedge clk)
    begin
        if (en[ST_MAG])
        begin
            mag_reg <= mag_next;
        end
        if (en[ST_PROD])
        begin
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(cfg.gear);
        end
        if (en[ST_NUM])
        begin
            num60_reg <= NUM60_W'({prod_reg, 6'b0}) - NUM60_W'({prod_reg, 2'b0});
        end
        if (en[ST_MUL])
        begin
            dn_reg <= DN_W'(num_full) * DN_W'(cfg.span);
        end
        if (en[ST_DIVIN])
        begin
            rem_reg[ST_DIVIN] <= REM_W'({dn_reg, 1'b0}) + REM_W'(cfg.den) - REM_W'(cfg.down);
            q_reg[ST_DIVIN]   <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_MAG])
        begin
            flag_reg[ST_MAG] <= '{dir: ~rate[N_W-1], dead: dead_next, cap: 1'b0};
        end
        for (int k = ST_PROD; k <= ST_DIV_LAST; k++)
        begin
            if (en[k])
            begin
                if (k == ST_MUL)
                begin
                    flag_reg[k] <= '{dir: flag_reg[k-1].dir, dead: flag_reg[k-1].dead,
                                     cap: cap_next};
                end
                else
                begin
                    flag_reg[k] <= flag_reg[k-1];
                end
            end
        end
    end

    for (genvar j = 0; j < DIV_BITS; j++)
    begin : g_div
        localparam int K = ST_DIV0 + j;
        localparam int B = DIV_BITS - 1 - j;
        logic [REM_W-1:0] dsh;
        logic             take;

        assign dsh  = REM_W'({cfg.den, 1'b0}) << B;
        assign take = rem_reg[K-1] >= dsh;

        always_ff @(posedge clk)
        begin
            if (en[K])
            begin
                q_reg[K] <= q_reg[K-1] | (PWM_W'(take) << B);
            end
        end

        if (j < DIV_BITS - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en[K])
                begin
                    rem_reg[K] <= take ? rem_reg[K-1] - dsh : rem_reg[K-1];
                end
            end
        end
    end

    always_comb
    begin
        if (flag_reg[ST_DIV_LAST].dead)
            duty_next = '0;
        else if (flag_reg[ST_DIV_LAST].cap)
            duty_next = cfg.hi;
        else if (cfg.down)
            duty_next = cfg.lo - q_reg[ST_DIV_LAST];
        else
            duty_next = cfg.lo + q_reg[ST_DIV_LAST];
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            duty_reg <= duty_next;
            dir_reg  <= flag_reg[ST_DIV_LAST].dir;
        end
    end

    assign duty = duty_reg;
    assign dir  = dir_reg;

endmodule

/* sv/mecanum_wheel_speed_to_pwm_top.sv */
// Mecanum wheel speed to PWM: body command in, duty and direction per wheel out.
// One transaction per cycle while the result side does not stall the full pipeline.
// The depth is set by the kinematics, ratio and cap stages plus an 8-stage divider.
// Stall on the result side holds only the full stages; bubbles still fill.
// Reset clears all valid bits and loads the configuration register defaults.
// Depends on mwsp_pkg, mwsp_cmd_if, mwsp_pwm_if, mwsp_kin and mwsp_wheel.
module mecanum_wheel_speed_to_pwm_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [mwsp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mwsp_pkg::CFG_DATA_W-1:0]    cfg_data,
    mwsp_cmd_if.sink                           cmd,
    mwsp_pwm_if.source                         pwm
);
    import mwsp_pkg::*;

    logic [RADIUS_W-1:0] wheel_radius_reg;
    logic [HALF_W-1:0]   half_length_reg;
    logic [HALF_W-1:0]   half_width_reg;
    logic [GEAR_W-1:0]   gear_ratio_reg;
    logic [RPM_W-1:0]    max_rpm_reg;
    logic [PWM_W-1:0]    min_pwm_reg;
    logic [PWM_W-1:0]    max_pwm_reg;
    logic [RM_W-1:0]     rm_reg;
    logic [DEN_W-1:0]    den_reg;
    cfg_t                cfg;
    stage_vec_t          v_reg;
    stage_vec_t          v_next;
    stage_vec_t          rdy;
    wheel_rate_t         rate [NUM_WHEELS];
    logic [PWM_W-1:0]    duty [NUM_WHEELS];
    logic                dir  [NUM_WHEELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_radius_reg <= RADIUS_RST;
            half_length_reg  <= HALF_RST;
            half_width_reg   <= HALF_RST;
            gear_ratio_reg   <= GEAR_RST;
            max_rpm_reg      <= RPM_RST;
            min_pwm_reg      <= MIN_PWM_RST;
            max_pwm_reg      <= MAX_PWM_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WHEEL_RADIUS: wheel_radius_reg <= cfg_data[RADIUS_W-1:0];
                REG_HALF_LENGTH:  half_length_reg  <= cfg_data[HALF_W-1:0];
                REG_HALF_WIDTH:   half_width_reg   <= cfg_data[HALF_W-1:0];
                REG_GEAR_RATIO:   gear_ratio_reg   <= cfg_data[GEAR_W-1:0];
                REG_MAX_RPM:      max_rpm_reg      <= cfg_data[RPM_W-1:0];
                REG_MIN_PWM:      min_pwm_reg      <= cfg_data[PWM_W-1:0];
                REG_MAX_PWM:      max_pwm_reg      <= cfg_data[PWM_W-1:0];
                default:          ;
            endcase
        end
    end

    // rpm-scaled divisor, registered in rm_reg and then in den_reg
    always_ff @(posedge clk)
    begin
        rm_reg  <= RM_W'(wheel_radius_reg) * RM_W'(max_rpm_reg);
        den_reg <= DEN_W'(rm_reg) * DEN_W'(TWO_PI_K);
    end

    always_comb
    begin
        cfg.radius = wheel_radius_reg;
        cfg.arm    = ARM_W'(half_length_reg) + ARM_W'(half_width_reg);
        cfg.gear   = gear_ratio_reg;
        cfg.den    = den_reg;
        cfg.lo     = min_pwm_reg;
        cfg.hi     = max_pwm_reg;
        cfg.down   = max_pwm_reg < min_pwm_reg;
        cfg.span   = cfg.down ? min_pwm_reg - max_pwm_reg : max_pwm_reg - min_pwm_reg;
    end

    for (genvar k = 1; k <= NUM_STAGES; k++)
    begin : g_ctl
        assign rdy[k] = pwm.ready || !(&v_reg[NUM_STAGES:k]);
        if (k == ST_IN)
        begin : g_first
            assign v_next[k] = rdy[k] ? cmd.valid : v_reg[k];
        end
        else
        begin : g_rest
            assign v_next[k] = rdy[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign cmd.ready = rdy[ST_IN];
    assign pwm.valid = v_reg[ST_OUT];

    mwsp_kin u_kin (
        .clk      (clk),
        .en       (rdy),
        .cfg      (cfg),
        .vel_x    (cmd.vel_x),
        .vel_y    (cmd.vel_y),
        .yaw_rate (cmd.yaw_rate),
        .rate     (rate)
    );

    for (genvar w = 0; w < NUM_WHEELS; w++)
    begin : g_wheel
        mwsp_wheel u_wheel (
            .clk  (clk),
            .en   (rdy),
            .cfg  (cfg),
            .rate (rate[w]),
            .duty (duty[w]),
            .dir  (dir[w])
        );
    end

    assign pwm.pwm_left_front  = duty[0];
    assign pwm.dir_left_front  = dir[0];
    assign pwm.pwm_right_front = duty[1];
    assign pwm.dir_right_front = dir[1];
    assign pwm.pwm_left_back   = duty[2];
    assign pwm.dir_left_back   = dir[2];
    assign pwm.pwm_right_back  = duty[3];
    assign pwm.dir_right_back  = dir[3];

`ifndef SYNTHESIS
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> v_reg[ST_IN])
        else $error("accepted command did not enter first stage");

    a_ready_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.ready && !pwm.ready) |-> !(&v_reg))
        else $error("input ready while every stage is full and stalled");

    a_duty_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pwm.valid |->
            (pwm.pwm_left_front  <= (cfg.down ? cfg.lo : cfg.hi)) &&
            (pwm.pwm_right_front <= (cfg.down ? cfg.lo : cfg.hi)) &&
            (pwm.pwm_left_back   <= (cfg.down ? cfg.lo : cfg.hi)) &&
            (pwm.pwm_right_back  <= (cfg.down ? cfg.lo : cfg.hi)))
        else $error("duty above configured PWM range");
`endif

endmodule
